[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/slts_pkg.sv]
package slts_pkg;

    localparam logic [16:0] DAY_SECONDS   = 17'd86400;
    localparam logic [16:0] LAST_SECOND   = 17'd86399;
    localparam logic [15:0] MS_PER_SECOND = 16'd1000;
    localparam logic [15:0] MS_SATURATE   = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_MAX   = 16'hFFFF;

    // Item operation codes
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_SECOND     = 2'd1;
    localparam logic [1:0] OP_LOAD_SEC   = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_READ_DIV  = 2'd0;
    localparam logic [1:0] REG_WRITE_DIV = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [1:0] REG_STEP_MS   = 2'd3;

    localparam logic [15:0] RST_READ_DIV  = 16'd9;
    localparam logic [7:0]  RST_WRITE_DIV = 8'd9;
    localparam logic [15:0] RST_TIMEOUT   = 16'd4800;
    localparam logic [9:0]  RST_STEP_MS   = 10'd25;

    typedef struct packed {
        logic [1:0]  operation;
        logic        button_pressed;
        logic [16:0] set_second;
    } t_in;

    typedef struct packed {
        logic        read_strobe;
        logic        write_strobe;
        logic [16:0] stamp_second;
        logic [15:0] stamp_ms;
        logic        stamp_valid;
        logic        day_rollover;
        logic        scope_power;
        logic [31:0] elapsed_ms;
    } t_out;

    typedef struct packed {
        logic [15:0] read_divide_limit;
        logic [7:0]  write_divide_limit;
        logic [15:0] scope_timeout_limit;
        logic [9:0]  stamp_step_ms;
    } t_cfg;

endpackage

[rtl/sample_log_tick_scheduler.sv]
// An accepted transaction passes through the input register, then the result register,
// to o_data; it waits in them while the receiver stalls with i_stall.
// Throughput: one transaction per cycle unless the receiver stalls; all scheduler state updates in one pass.
// Reset (synchronous, i_rst_n low): counters, time and stamp state cleared, scope power on,
// registers back to defaults, both pipeline stages emptied.
module sample_log_tick_scheduler
    import slts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;
    t_out w_result;

    logic r_in_valid;
    t_in  r_in_data;
    logic r_out_valid;
    t_out r_out_data;
    logic w_move;
    logic w_accept;

    slts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    slts_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_move),
        .i_item    (r_in_data),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    // item moves on when the result register is empty or being drained
    assign w_move   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !w_move;
    assign w_accept = i_valid && !o_stall;

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_data <= i_data;
        end
        if (w_move) begin
            r_out_data <= w_result;
        end
    end

endmodule

[rtl/slts_cfg.sv]
module slts_cfg
    import slts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr_en;

    assign w_wr_en = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_divide_limit   <= RST_READ_DIV;
            r_cfg.write_divide_limit  <= RST_WRITE_DIV;
            r_cfg.scope_timeout_limit <= RST_TIMEOUT;
            r_cfg.stamp_step_ms       <= RST_STEP_MS;
        end else if (w_wr_en) begin
            case (paddr[3:2])
                REG_READ_DIV:  r_cfg.read_divide_limit   <= pwdata[15:0];
                REG_WRITE_DIV: r_cfg.write_divide_limit  <= pwdata[7:0];
                REG_TIMEOUT:   r_cfg.scope_timeout_limit <= pwdata[15:0];
                REG_STEP_MS:   r_cfg.stamp_step_ms       <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_READ_DIV:  prdata = {16'd0, r_cfg.read_divide_limit};
            REG_WRITE_DIV: prdata = {24'd0, r_cfg.write_divide_limit};
            REG_TIMEOUT:   prdata = {16'd0, r_cfg.scope_timeout_limit};
            REG_STEP_MS:   prdata = {22'd0, r_cfg.stamp_step_ms};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

[rtl/slts_core.sv]
`include "assert_macros.svh"

module slts_core
    import slts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_advance,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_result
);

    logic [15:0] r_tick_count, n_tick_count;
    logic [7:0]  r_read_count, n_read_count;
    logic [15:0] r_timeout_count, n_timeout_count;
    logic [1:0]  r_quarter_ms, n_quarter_ms;
    logic [31:0] r_ms_total, n_ms_total;
    logic [16:0] r_day_second, n_day_second;
    logic [15:0] r_sub_ms, n_sub_ms;
    logic        r_scope_on, n_scope_on;

    logic [15:0] w_tick_inc;
    logic        w_rd;
    logic [7:0]  w_read_inc;
    logic        w_wr;
    logic [16:0] w_sub_sum;
    logic [16:0] w_sec_inc;
    logic        w_roll;

    assign w_tick_inc = r_tick_count + 16'd1;
    assign w_rd       = w_tick_inc > i_cfg.read_divide_limit;
    assign w_read_inc = w_rd ? r_read_count + 8'd1 : r_read_count;
    assign w_wr       = w_read_inc > i_cfg.write_divide_limit;
    assign w_sub_sum  = {1'b0, r_sub_ms} + {7'd0, i_cfg.stamp_step_ms};
    assign w_sec_inc  = r_day_second + 17'd1;
    assign w_roll     = (i_item.operation == OP_SECOND) && (w_sec_inc >= DAY_SECONDS);

    always_comb begin
        n_tick_count    = r_tick_count;
        n_read_count    = r_read_count;
        n_timeout_count = r_timeout_count;
        n_quarter_ms    = r_quarter_ms;
        n_ms_total      = r_ms_total;
        n_day_second    = r_day_second;
        n_sub_ms        = r_sub_ms;
        n_scope_on      = r_scope_on;

        o_result              = '0;
        case (i_item.operation)
            OP_TICK: begin
                n_tick_count = w_rd ? 16'd0 : w_tick_inc;
                n_read_count = w_wr ? 8'd0 : w_read_inc;
                if (w_wr && (r_timeout_count != TIMEOUT_MAX)) begin
                    n_timeout_count = r_timeout_count + 16'd1;
                end
                n_quarter_ms = r_quarter_ms + 2'd1;
                if (r_quarter_ms == 2'd3) begin
                    n_ms_total = r_ms_total + 32'd1;
                end
                if (w_rd && i_item.button_pressed) begin
                    n_scope_on      = 1'b1;
                    n_timeout_count = 16'd0;
                end
                if (w_wr) begin
                    o_result.stamp_second = r_day_second;
                    o_result.stamp_ms     = r_sub_ms;
                    o_result.stamp_valid  = r_sub_ms < MS_PER_SECOND;
                    n_sub_ms = w_sub_sum[16] ? MS_SATURATE : w_sub_sum[15:0];
                end
                o_result.read_strobe  = w_rd;
                o_result.write_strobe = w_wr;
            end
            OP_SECOND: begin
                n_sub_ms     = 16'd0;
                n_day_second = w_roll ? 17'd0 : w_sec_inc;
            end
            OP_LOAD_SEC: begin
                n_day_second = (i_item.set_second >= DAY_SECONDS) ? LAST_SECOND
                                                                  : i_item.set_second;
            end
            default: ;
        endcase

        // timeout check runs after every item
        if (n_scope_on && (n_timeout_count > i_cfg.scope_timeout_limit)) begin
            n_timeout_count = 16'd0;
            n_scope_on      = 1'b0;
        end

        o_result.day_rollover = w_roll;
        o_result.scope_power  = n_scope_on;
        o_result.elapsed_ms   = n_ms_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count    <= 16'd0;
            r_read_count    <= 8'd0;
            r_timeout_count <= 16'd0;
            r_quarter_ms    <= 2'd0;
            r_ms_total      <= 32'd0;
            r_day_second    <= 17'd0;
            r_sub_ms        <= 16'd0;
            r_scope_on      <= 1'b1;
        end else if (i_advance) begin
            r_tick_count    <= n_tick_count;
            r_read_count    <= n_read_count;
            r_timeout_count <= n_timeout_count;
            r_quarter_ms    <= n_quarter_ms;
            r_ms_total      <= n_ms_total;
            r_day_second    <= n_day_second;
            r_sub_ms        <= n_sub_ms;
            r_scope_on      <= n_scope_on;
        end
    end

    `ASSERT_ALWAYS(a_day_in_range, i_clk, i_rst_n, r_day_second < DAY_SECONDS, "day second out of range")
    `ASSERT_NEXT(a_wr_clears_reads, i_clk, i_rst_n, i_advance && o_result.write_strobe, r_read_count == 8'd0, "read count not cleared by write strobe")
    `ASSERT_NEXT(a_roll_clears_day, i_clk, i_rst_n, i_advance && o_result.day_rollover, (r_day_second == 17'd0) && (r_sub_ms == 16'd0), "rollover did not clear time")

endmodule

[tb/tb_sample_log_tick_scheduler.sv]
module tb_sample_log_tick_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import slts_pkg::*;

    // operation code the block leaves unused: only the timeout check runs
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int         IDLE_PCT = 23;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sample_log_tick_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // scheduler state as the testbench sees it
    t_cfg        cfg;
    logic [15:0] tick_cnt;
    logic [7:0]  read_cnt;
    logic [15:0] timeout_cnt;
    logic [1:0]  quarter_cnt;
    logic [31:0] ms_count;
    logic [16:0] day_sec;
    logic [15:0] sub_ms;
    logic        scope_on;

    t_out        predicted_reports[$];
    t_out        want_report;

    bit          send_gaps;
    bit          recv_gaps;
    int          hold_left;
    int          error_count;
    int          n_sent;
    int          n_checked;
    int          n_stamps;
    int          n_rollovers;
    int          n_scope_off;

    task automatic clear_schedule();
        cfg.read_divide_limit   = RST_READ_DIV;
        cfg.write_divide_limit  = RST_WRITE_DIV;
        cfg.scope_timeout_limit = RST_TIMEOUT;
        cfg.stamp_step_ms       = RST_STEP_MS;
        tick_cnt    = '0;
        read_cnt    = '0;
        timeout_cnt = '0;
        quarter_cnt = '0;
        ms_count    = '0;
        day_sec     = '0;
        sub_ms      = '0;
        scope_on    = 1'b1;
    endtask

    function automatic t_out schedule_event(t_in ev);
        t_out        r;
        logic [16:0] ms_sum;
        r = '0;
        case (ev.operation)
            OP_TICK: begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt > cfg.read_divide_limit) begin
                    r.read_strobe = 1'b1;
                    tick_cnt = '0;
                    read_cnt = read_cnt + 8'd1;
                end
                // compared on every tick, so a lowered limit can fire without a read
                if (read_cnt > cfg.write_divide_limit) begin
                    r.write_strobe = 1'b1;
                    read_cnt = '0;
                    if (timeout_cnt != TIMEOUT_MAX)
                        timeout_cnt = timeout_cnt + 16'd1;
                end
                if (quarter_cnt == 2'd3)
                    ms_count = ms_count + 32'd1;
                quarter_cnt = quarter_cnt + 2'd1;
                if (r.read_strobe && ev.button_pressed) begin
                    scope_on = 1'b1;
                    timeout_cnt = '0;
                end
                if (r.write_strobe) begin
                    r.stamp_second = day_sec;
                    r.stamp_ms     = sub_ms;
                    r.stamp_valid  = (sub_ms < MS_PER_SECOND);
                    ms_sum = {1'b0, sub_ms} + {7'd0, cfg.stamp_step_ms};
                    sub_ms = ms_sum[16] ? MS_SATURATE : ms_sum[15:0];
                end
            end
            OP_SECOND: begin
                day_sec = day_sec + 17'd1;
                sub_ms  = '0;
                if (day_sec >= DAY_SECONDS) begin
                    day_sec = '0;
                    r.day_rollover = 1'b1;
                end
            end
            OP_LOAD_SEC: begin
                day_sec = (ev.set_second >= DAY_SECONDS) ? LAST_SECOND : ev.set_second;
            end
            default: ;
        endcase
        if (scope_on && timeout_cnt > cfg.scope_timeout_limit) begin
            timeout_cnt = '0;
            scope_on = 1'b0;
            n_scope_off++;
        end
        r.scope_power = scope_on;
        r.elapsed_ms  = ms_count;
        return r;
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function automatic t_in make_event(logic [1:0] op, logic btn, logic [16:0] sec);
        t_in e;
        e.operation      = op;
        e.button_pressed = btn;
        e.set_second     = sec;
        return e;
    endfunction

    // tick_pct: share of ticks; the rest splits between pulses, loads and the unused code
    function automatic t_in random_event(int tick_pct);
        t_in         e;
        int unsigned pick;
        int unsigned rest;
        pick = $urandom_range(99);
        rest = $urandom_range(9);
        if (pick < tick_pct)
            e.operation = OP_TICK;
        else if (rest < 4)
            e.operation = OP_SECOND;
        else if (rest < 8)
            e.operation = OP_LOAD_SEC;
        else
            e.operation = OP_NONE;
        e.button_pressed = 1'($urandom_range(1));
        case ($urandom_range(9))
            0:       e.set_second = 17'($urandom_range(131071, 86399));
            1, 2:    e.set_second = 17'($urandom_range(86399, 86380));
            default: e.set_second = 17'($urandom_range(86399));
        endcase
        return e;
    endfunction

    task automatic send_item(input t_in ev);
        if (send_gaps)
            while ($urandom_range(99) < IDLE_PCT) @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = ev;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted_reports.push_back(schedule_event(ev));
        n_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (predicted_reports.size() != 0) @(posedge i_clk);
        // two-stage pipeline, plus margin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write one register, then read it back
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            REG_READ_DIV:  cfg.read_divide_limit   = value[15:0];
            REG_WRITE_DIV: cfg.write_divide_limit  = value[7:0];
            REG_TIMEOUT:   cfg.scope_timeout_limit = value[15:0];
            REG_STEP_MS:   cfg.stamp_step_ms       = value[9:0];
            default: ;
        endcase
        case (idx)
            REG_READ_DIV:  stored = {16'd0, cfg.read_divide_limit};
            REG_WRITE_DIV: stored = {24'd0, cfg.write_divide_limit};
            REG_TIMEOUT:   stored = {16'd0, cfg.scope_timeout_limit};
            default:       stored = {22'd0, cfg.stamp_step_ms};
        endcase
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        compare_field("register readback", stored, prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_schedule(input logic [15:0] rd_lim, input logic [7:0] wr_lim,
                                input logic [15:0] to_lim, input logic [9:0] step);
        set_reg(REG_READ_DIV,  {16'd0, rd_lim});
        set_reg(REG_WRITE_DIV, {24'd0, wr_lim});
        set_reg(REG_TIMEOUT,   {16'd0, to_lim});
        set_reg(REG_STEP_MS,   {22'd0, step});
    endtask

    // receiver: random stalls, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (recv_gaps) begin
            i_stall = ($urandom_range(99) < IDLE_PCT);
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_reports.size() == 0) begin
                error_count++;
                $display("%0t ns: result with nothing predicted, expected none, got %h",
                         $time, o_data);
            end else begin
                want_report = predicted_reports.pop_front();
                compare_field("read_strobe", 32'(want_report.read_strobe),
                              32'(o_data.read_strobe));
                compare_field("write_strobe", 32'(want_report.write_strobe),
                              32'(o_data.write_strobe));
                compare_field("stamp_second", 32'(want_report.stamp_second),
                              32'(o_data.stamp_second));
                compare_field("stamp_ms", 32'(want_report.stamp_ms),
                              32'(o_data.stamp_ms));
                compare_field("stamp_valid", 32'(want_report.stamp_valid),
                              32'(o_data.stamp_valid));
                compare_field("day_rollover", 32'(want_report.day_rollover),
                              32'(o_data.day_rollover));
                compare_field("scope_power", 32'(want_report.scope_power),
                              32'(o_data.scope_power));
                compare_field("elapsed_ms", want_report.elapsed_ms, o_data.elapsed_ms);
                n_checked++;
                if (want_report.write_strobe) n_stamps++;
                if (want_report.day_rollover) n_rollovers++;
            end
        end
    end

    // reset defaults: ticks, pulses, loads incl. clamping, the unused code
    task automatic test_time_of_day();
        send_item(make_event(OP_TICK,     1'b0, 17'd0));
        send_item(make_event(OP_TICK,     1'b1, 17'd0));
        send_item(make_event(OP_NONE,     1'b1, 17'h1FFFF));
        send_item(make_event(OP_LOAD_SEC, 1'b0, LAST_SECOND));
        send_item(make_event(OP_SECOND,   1'b0, 17'd0));
        send_item(make_event(OP_SECOND,   1'b1, 17'h1FFFF));
        send_item(make_event(OP_LOAD_SEC, 1'b0, DAY_SECONDS));
        send_item(make_event(OP_SECOND,   1'b0, 17'd0));
        send_item(make_event(OP_LOAD_SEC, 1'b1, 17'h1FFFF));
        send_item(make_event(OP_LOAD_SEC, 1'b0, 17'd0));
        send_item(make_event(OP_LOAD_SEC, 1'b0, 17'h10000));
        send_item(make_event(OP_SECOND,   1'b0, 17'd0));
    endtask

    // strobe every tick, zero timeout, largest step
    task automatic test_strobes_and_scope();
        wait_idle();
        set_schedule(16'd0, 8'd0, 16'd0, 10'd1023);
        send_item(make_event(OP_TICK,     1'b0, 17'd0));
        send_item(make_event(OP_TICK,     1'b1, 17'd0));
        send_item(make_event(OP_TICK,     1'b0, 17'd0));
        send_item(make_event(OP_SECOND,   1'b0, 17'd0));
        send_item(make_event(OP_TICK,     1'b1, 17'd0));
        send_item(make_event(OP_LOAD_SEC, 1'b0, LAST_SECOND));
        send_item(make_event(OP_TICK,     1'b0, 17'd0));
        send_item(make_event(OP_NONE,     1'b0, 17'd0));
        send_item(make_event(OP_TICK,     1'b1, 17'd0));
    endtask

    // pile up read strobes behind a high write limit, then lower it
    task automatic test_lowered_write_limit();
        wait_idle();
        set_schedule(16'd0, 8'd255, 16'd65535, 10'd1000);
        repeat (20) send_item(make_event(OP_TICK, 1'($urandom_range(1)), 17'd0));
        wait_idle();
        set_reg(REG_WRITE_DIV, 32'd3);
        repeat (4) send_item(make_event(OP_TICK, 1'($urandom_range(1)), 17'd0));
    endtask

    task automatic test_random_schedules();
        int tick_pct;
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            tick_pct = 80;
            case (ph)
                0: set_schedule(16'd0, 8'd0, 16'd0, 10'd0);
                1: begin
                    // few pulses, so the stamp reaches saturation
                    set_schedule(16'd0, 8'd0, 16'd3, 10'd1023);
                    tick_pct = 99;
                end
                2: set_schedule(16'd65535, 8'd255, 16'd65535, 10'd1023);
                3: set_schedule(16'd1, 8'd2, 16'd5, 10'd1000);
                default: set_schedule(16'($urandom_range(3)), 8'($urandom_range(3)),
                                      16'($urandom_range(30)), 10'($urandom_range(1023)));
            endcase
            repeat (150) send_item(random_event(tick_pct));
        end
    endtask

    task automatic test_streaming();
        wait_idle();
        set_schedule(16'($urandom_range(2)), 8'($urandom_range(2)), 16'($urandom_range(10)),
                     10'($urandom_range(1023)));
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (300) send_item(random_event(90));
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, then the sender drains
    task automatic test_backpressure();
        wait_idle();
        send_gaps = 1'b0;
        hold_left = 200;
        repeat (60) send_item(random_event(85));
        wait_idle();
        send_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        send_gaps   = 1'b1;
        recv_gaps   = 1'b1;
        hold_left   = 0;
        error_count = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_stamps    = 0;
        n_rollovers = 0;
        n_scope_off = 0;
        clear_schedule();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_time_of_day();
        test_strobes_and_scope();
        test_lowered_write_limit();
        test_random_schedules();
        test_streaming();
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d events, checked %0d results: %0d write stamps, %0d day rollovers,",
                 n_sent, n_checked, n_stamps, n_rollovers);
        $display("scope power switched off %0d times, over 14 register settings.", n_scope_off);
        if (error_count == 0 && predicted_reports.size() == 0) begin
            $display("[sample_log_tick_scheduler] OK");
        end else begin
            $display("%0d mismatches, %0d results still outstanding",
                     error_count, predicted_reports.size());
            $display("[sample_log_tick_scheduler] ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[sample_log_tick_scheduler] ERROR");
        $finish;
    end

endmodule
